FILE: rtl/framed_message_deframer_top_macros.svh
// Assertion macros shared by the deframer modules.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef FRAMED_MESSAGE_DEFRAMER_TOP_MACROS_SVH
`define FRAMED_MESSAGE_DEFRAMER_TOP_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define FMD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define FMD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/fmd_pkg.sv
// ----------------------------------------------------------------------------
// fmd_pkg
// Shared constants, codes and types of the framed message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package fmd_pkg;

    // Payload buffer geometry.
    localparam int MAX_PAYLOAD = 64;
    localparam int OFS_W       = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int NUM_BANKS   = 2;
    localparam int BANK_W      = $clog2(NUM_BANKS);
    localparam int RAM_DEPTH   = NUM_BANKS * MAX_PAYLOAD;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);

    // Queue depths.
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
    localparam int OUTQ_DEPTH  = 2;
    localparam int OUTQ_AW     = $clog2(OUTQ_DEPTH);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POSE_ID    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POSE_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_ID   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SIZE = 3'd5;

    // Message kinds.
    localparam logic KIND_POSE  = 1'b0;
    localparam logic KIND_SPEED = 1'b1;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_ID    = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_TRAIL = 3'd4
    } phase_t;

    // One accepted frame, handed from the parser to the read-out side.
    typedef struct packed {
        logic              kind;
        logic [BANK_W-1:0] bank;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic             kind;
        logic [OFS_W-1:0] ofs;
        logic [7:0]       data;
        logic             last;
    } out_t;

endpackage

`default_nettype wire

FILE: rtl/framed_message_deframer_top.sv
// ----------------------------------------------------------------------------
// framed_message_deframer_top
// Byte-stream frame parser that emits the payload of accepted frames.
//
//   Channel   Handshake          Payload
//   -------   ----------------   -----------------------------------------
//   input     push / full        rx_byte
//   result    pop / empty        msg_kind, byte_offset, payload_byte,
//                                last_byte
//   config    cfg_we             cfg_index, cfg_data
//
// One input byte is taken per cycle while full is low.
// A run of N result bytes passes the frame queue, the RAM read and the result
// queue, one byte per cycle while the result queue has room, limited by the
// single RAM read port. The payload RAM has two banks; full rises while both
// hold frames that are still being read out.
// rst_n clears all control state at once; the payload RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_message_deframer_top import fmd_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 pop,
    output logic                      empty,
    output logic                      msg_kind,
    output logic [OFS_W-1:0]          byte_offset,
    output logic [7:0]                payload_byte,
    output logic                      last_byte
);

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [RAM_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic              cmd_push;
    cmd_t              cmd_wdata;
    cmd_t              cmd_rdata;
    logic              cmd_pop;
    logic              cmd_valid;
    logic              cmd_full;

    // Parser front end.
    fmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .rx_byte   (rx_byte),
        .full      (full),
        .q_full    (cmd_full),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_wdata)
    );

    // Payload buffer.
    fmd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Accepted frames waiting for read-out.
    fmd_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .valid (cmd_valid),
        .full  (cmd_full)
    );

    // Read-out back end.
    fmd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_data     (cmd_rdata),
        .cmd_pop      (cmd_pop),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .pop          (pop),
        .empty        (empty),
        .msg_kind     (msg_kind),
        .byte_offset  (byte_offset),
        .payload_byte (payload_byte),
        .last_byte    (last_byte)
    );

endmodule

`default_nettype wire

FILE: rtl/fmd_ram.sv
// ----------------------------------------------------------------------------
// fmd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/fmd_cmdq.sv
// ----------------------------------------------------------------------------
// fmd_cmdq
// Short queue of accepted frames between the parser and the read-out side.
// ----------------------------------------------------------------------------
`default_nettype none
`include "framed_message_deframer_top_macros.svh"

module fmd_cmdq import fmd_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t wdata,
    input  wire logic pop,
    output cmd_t      rdata,
    output logic      valid,
    output logic      full
);

    cmd_t               entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg;
    logic [CMDQ_AW-1:0] rd_ptr_reg;
    logic [CMDQ_AW:0]   count_reg;

    assign valid = (count_reg != '0);
    assign full  = (count_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign rdata = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    `FMD_ASSERT_NEVER(a_cmdq_overflow, push && full && !pop, "frame pushed into a full queue")
    `FMD_ASSERT_NEVER(a_cmdq_underflow, pop && !valid, "frame popped from an empty queue")

endmodule

`default_nettype wire

FILE: rtl/fmd_front.sv
// ----------------------------------------------------------------------------
// fmd_front
// Byte parser: hunts for frames, stores the payload and checks the trailer.
// ----------------------------------------------------------------------------
`default_nettype none

module fmd_front import fmd_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 push,
    input  wire logic [7:0]           rx_byte,
    output logic                      full,
    input  wire logic                 q_full,
    output logic                      ram_we,
    output logic [RAM_AW-1:0]         ram_waddr,
    output logic [7:0]                ram_wdata,
    output logic                      cmd_push,
    output cmd_t                      cmd_data
);

    logic [7:0]        start_byte_reg;
    logic [7:0]        end_byte_reg;
    logic [7:0]        pose_id_reg;
    logic [6:0]        pose_size_reg;
    logic [7:0]        speed_id_reg;
    logic [6:0]        speed_size_reg;

    phase_t            phase_reg, phase_next;
    logic [7:0]        frame_id_reg, frame_id_next;
    logic [7:0]        frame_len_reg, frame_len_next;
    logic [7:0]        fill_reg, fill_next;
    logic [BANK_W-1:0] bank_reg;

    logic              accept;
    logic [7:0]        fill_inc;
    logic              is_pose;
    logic              frame_ok;

    // Input is held off while every payload bank holds a frame not yet read out.
    assign full   = q_full;
    assign accept = push && !q_full;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= 8'd0;
            end_byte_reg   <= 8'd0;
            pose_id_reg    <= 8'd0;
            pose_size_reg  <= 7'd1;
            speed_id_reg   <= 8'd1;
            speed_size_reg <= 7'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_BYTE: start_byte_reg <= cfg_data;
                CFG_END_BYTE:   end_byte_reg   <= cfg_data;
                CFG_POSE_ID:    pose_id_reg    <= cfg_data;
                CFG_POSE_SIZE:  pose_size_reg  <= cfg_data[6:0];
                CFG_SPEED_ID:   speed_id_reg   <= cfg_data;
                CFG_SPEED_SIZE: speed_size_reg <= cfg_data[6:0];
                default:        ;
            endcase
        end
    end

    // Trailer check. Equal ids are checked as a pose frame only.
    assign is_pose  = (frame_id_reg == pose_id_reg);
    assign frame_ok = (rx_byte == end_byte_reg)
                   && (frame_len_reg <= 8'(MAX_PAYLOAD))
                   && ((is_pose && (frame_len_reg == {1'b0, pose_size_reg}))
                    || (!is_pose && (frame_id_reg == speed_id_reg)
                        && (frame_len_reg == {1'b0, speed_size_reg})));

    // The payload count saturates at its top value.
    assign fill_inc = (fill_reg != 8'hFF) ? (fill_reg + 8'd1) : fill_reg;

    assign ram_waddr = {bank_reg, fill_reg[OFS_W-1:0]};
    assign ram_wdata = rx_byte;

    assign cmd_data.kind = is_pose ? KIND_POSE : KIND_SPEED;
    assign cmd_data.bank = bank_reg;
    assign cmd_data.len  = frame_len_reg[LEN_W-1:0];

    // Parser state register and frame header registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            frame_id_reg  <= 8'd0;
            frame_len_reg <= 8'd0;
            fill_reg      <= 8'd0;
            bank_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            frame_id_reg  <= frame_id_next;
            frame_len_reg <= frame_len_next;
            fill_reg      <= fill_next;
            if (cmd_push)
            begin
                bank_reg <= bank_reg + 1'b1;
            end
        end
    end

    // Next state and outputs of the parser.
    always_comb
    begin
        phase_next     = phase_reg;
        frame_id_next  = frame_id_reg;
        frame_len_next = frame_len_reg;
        fill_next      = fill_reg;
        ram_we         = 1'b0;
        cmd_push       = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_ID:
                begin
                    frame_id_next = rx_byte;
                    phase_next    = PH_LEN;
                end
                PH_LEN:
                begin
                    frame_len_next = rx_byte;
                    phase_next     = PH_DATA;
                end
                PH_DATA:
                begin
                    // Bytes beyond the buffer are counted but not stored.
                    ram_we = (fill_reg < 8'(MAX_PAYLOAD));
                    if (fill_inc >= frame_len_reg)
                    begin
                        fill_next  = 8'd0;
                        phase_next = PH_TRAIL;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
                PH_TRAIL:
                begin
                    // A matching frame of length zero produces no run.
                    phase_next = PH_START;
                    cmd_push   = frame_ok && (frame_len_reg != 8'd0);
                end
                default:
                begin
                    frame_id_next  = 8'd0;
                    frame_len_next = 8'd0;
                    fill_next      = 8'd0;
                    phase_next     = (rx_byte == start_byte_reg) ? PH_ID : PH_START;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fmd_back.sv
// ----------------------------------------------------------------------------
// fmd_back
// Read-out side: walks each accepted frame's payload into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "framed_message_deframer_top_macros.svh"

module fmd_back import fmd_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cmd_valid,
    input  wire cmd_t         cmd_data,
    output logic              cmd_pop,
    output logic [RAM_AW-1:0] ram_raddr,
    input  wire logic [7:0]   ram_rdata,
    input  wire logic         pop,
    output logic              empty,
    output logic              msg_kind,
    output logic [OFS_W-1:0]  byte_offset,
    output logic [7:0]        payload_byte,
    output logic              last_byte
);

    logic [OFS_W-1:0]   idx_reg;
    logic               pend_reg;
    logic               pend_kind_reg;
    logic [OFS_W-1:0]   pend_ofs_reg;
    logic               pend_last_reg;

    out_t               entry_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] wr_ptr_reg;
    logic [OUTQ_AW-1:0] rd_ptr_reg;
    logic [OUTQ_AW:0]   count_reg;

    logic               pop_fire;
    logic               has_room;
    logic               issue;
    logic               cur_last;
    out_t               head;
    out_t               wr_entry;

    assign empty    = (count_reg == '0);
    assign pop_fire = pop && !empty;

    // A read is issued only when the queue has room for it and any read in flight.
    assign has_room = ({1'b0, count_reg} + {{OUTQ_AW+1{1'b0}}, pend_reg})
                    < ((OUTQ_AW+2)'(OUTQ_DEPTH) + {{OUTQ_AW+1{1'b0}}, pop_fire});
    assign issue    = cmd_valid && has_room;
    assign cur_last = (({1'b0, idx_reg} + {{OFS_W{1'b0}}, 1'b1}) == cmd_data.len);
    assign cmd_pop  = issue && cur_last;

    assign ram_raddr = {cmd_data.bank, idx_reg};

    // Byte index within the current run, and the read in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
            if (issue)
            begin
                idx_reg <= cur_last ? '0 : (idx_reg + 1'b1);
            end
        end
    end

    // Result fields that travel alongside the RAM read.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_kind_reg <= cmd_data.kind;
            pend_ofs_reg  <= idx_reg;
            pend_last_reg <= cur_last;
        end
    end

    assign wr_entry.kind = pend_kind_reg;
    assign wr_entry.ofs  = pend_ofs_reg;
    assign wr_entry.data = ram_rdata;
    assign wr_entry.last = pend_last_reg;

    // Result queue pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (pend_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (pend_reg && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_fire && !pend_reg)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            entry_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign msg_kind     = head.kind;
    assign byte_offset  = head.ofs;
    assign payload_byte = head.data;
    assign last_byte    = head.last;

    `FMD_ASSERT_NEVER(a_outq_overflow,
        pend_reg && !pop_fire && (count_reg == (OUTQ_AW+1)'(OUTQ_DEPTH)),
        "read data arrived with the result queue full")
    `FMD_ASSERT_IMPL(a_run_ends_with_pop, issue && cur_last, cmd_pop,
        "run finished without releasing its frame")

endmodule

`default_nettype wire

FILE: test/tb_framed_message_deframer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_framed_message_deframer_top
// Self-checking testbench for the framed message deframer. A scoreboard class
// tracks the parser state and configuration, predicts the payload run of
// every frame that passes the trailer, id and length checks, and compares
// each result transfer field by field. Stimulus is a short directed stream
// at the reset configuration, then randomized frame traffic under several
// register settings and idle patterns, including a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_framed_message_deframer_top import fmd_pkg::*; ();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_OFF_LEN  = 300;

    // Register indexes past the end of the register list.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Predicts the payload runs of accepted frames and checks the results.
    class deframe_scoreboard;
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] pose_id;
        logic [6:0] pose_size;
        logic [7:0] speed_id;
        logic [6:0] speed_size;
        phase_t     phase;
        logic [7:0] frame_id;
        logic [7:0] frame_len;
        logic [7:0] fill_cnt;
        logic [7:0] payload_mem [MAX_PAYLOAD];
        out_t       expected_beats [$];
        int         errors;

        function new();
            start_byte = 8'h00;
            end_byte   = 8'h00;
            pose_id    = 8'h00;
            pose_size  = 7'd1;
            speed_id   = 8'h01;
            speed_size = 7'd1;
            phase      = PH_START;
            frame_id   = 8'h00;
            frame_len  = 8'h00;
            fill_cnt   = 8'h00;
            errors     = 0;
        endfunction

        // Registers past the list are ignored; sizes keep their low 7 bits.
        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
            case (idx)
                CFG_START_BYTE: start_byte = value;
                CFG_END_BYTE:   end_byte   = value;
                CFG_POSE_ID:    pose_id    = value;
                CFG_POSE_SIZE:  pose_size  = value[6:0];
                CFG_SPEED_ID:   speed_id   = value;
                CFG_SPEED_SIZE: speed_size = value[6:0];
                default:        ;
            endcase
        endfunction

        function void queue_run(input logic kind, input logic [7:0] len);
            out_t beat;
            int   k;
            for (k = 0; k < len; k++)
            begin
                beat.kind = kind;
                beat.ofs  = k[OFS_W-1:0];
                beat.data = payload_mem[k[OFS_W-1:0]];
                beat.last = (k == len - 1);
                expected_beats.push_back(beat);
            end
        endfunction

        // Advances the parser by one accepted byte.
        function void take_rx_byte(input logic [7:0] b);
            case (phase)
                PH_ID:
                begin
                    frame_id = b;
                    phase    = PH_LEN;
                end
                PH_LEN:
                begin
                    frame_len = b;
                    phase     = PH_DATA;
                end
                PH_DATA:
                begin
                    // Bytes beyond the buffer are counted but not stored.
                    if (fill_cnt < MAX_PAYLOAD)
                        payload_mem[fill_cnt[OFS_W-1:0]] = b;
                    if (fill_cnt != 8'hFF)
                        fill_cnt = fill_cnt + 8'd1;
                    if (fill_cnt >= frame_len)
                    begin
                        fill_cnt = 8'h00;
                        phase    = PH_TRAIL;
                    end
                end
                PH_TRAIL:
                begin
                    phase = PH_START;
                    // With equal ids the frame is only checked as a pose frame.
                    if (b == end_byte && frame_len <= MAX_PAYLOAD)
                    begin
                        if (frame_id == pose_id)
                        begin
                            if (frame_len == pose_size)
                                queue_run(KIND_POSE, frame_len);
                        end
                        else if (frame_id == speed_id && frame_len == speed_size)
                            queue_run(KIND_SPEED, frame_len);
                    end
                end
                default:
                begin
                    frame_id  = 8'h00;
                    frame_len = 8'h00;
                    fill_cnt  = 8'h00;
                    phase     = (b == start_byte) ? PH_ID : PH_START;
                end
            endcase
        endfunction

        function void compare_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_payload_beat(input out_t got);
            out_t want;
            if (expected_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, %s %0d %0d %0d %0d",
                         $time, "actual kind/offset/byte/last",
                         got.kind, got.ofs, got.data, got.last);
                return;
            end
            want = expected_beats.pop_front();
            compare_field("msg_kind", 8'(want.kind), 8'(got.kind));
            compare_field("byte_offset", 8'(want.ofs), 8'(got.ofs));
            compare_field("payload_byte", want.data, got.data);
            compare_field("last_byte", 8'(want.last), 8'(got.last));
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;
    logic                 push;
    logic                 full;
    logic [7:0]           rx_byte;
    logic                 pop;
    logic                 empty;
    logic                 msg_kind;
    logic [OFS_W-1:0]     byte_offset;
    logic [7:0]           payload_byte;
    logic                 last_byte;

    deframe_scoreboard sb = new();

    int send_idle_pct = 36;
    int recv_idle_pct = 50;
    int hold_off_left = 0;
    int rx_count      = 0;
    int cycle_count   = 0;

    // Short stream at the reset configuration: a pose frame, a speed frame,
    // a bad trailer and a zero-length frame, after one ignored noise byte.
    logic [7:0] directed_stream [21] = '{
        8'h5A,
        8'h00, 8'h00, 8'h01, 8'hFF, 8'h00,
        8'h00, 8'h01, 8'h01, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h01, 8'h55, 8'h7F,
        8'h00, 8'h00, 8'h00, 8'hAA, 8'h00
    };

    framed_message_deframer_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .pop          (pop),
        .empty        (empty),
        .msg_kind     (msg_kind),
        .byte_offset  (byte_offset),
        .payload_byte (payload_byte),
        .last_byte    (last_byte)
    );

    always #1 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Input transfers feed the predictor, result transfers are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.take_rx_byte(rx_byte);
            if (pop && !empty)
                sb.check_payload_beat(out_t'{kind: msg_kind, ofs: byte_offset,
                                             data: payload_byte, last: last_byte});
        end
    end

    // Receiver: random pop, or a long hold-off when one is requested.
    initial
    begin
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                pop <= 1'b0;
                hold_off_left--;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one byte and waits for its transfer.
    task automatic send_rx_byte(input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= value;
        @(posedge clk);
        while (full)
            @(posedge clk);
        rx_count++;
    endtask

    // Start byte, id, length, payload (at least one byte), trailer.
    task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                              input logic [7:0] trailer);
        int n;
        send_rx_byte(sb.start_byte);
        send_rx_byte(id);
        send_rx_byte(len);
        n = (len == 0) ? 1 : len;
        repeat (n)
            send_rx_byte(8'($urandom_range(255)));
        send_rx_byte(trailer);
    endtask

    task automatic send_valid_frame();
        if ($urandom_range(1))
            send_frame(sb.speed_id, {1'b0, sb.speed_size}, sb.end_byte);
        else
            send_frame(sb.pose_id, {1'b0, sb.pose_size}, sb.end_byte);
    endtask

    // Mostly well-formed frames, the rest noise and broken frames.
    task automatic send_random_traffic(input int quota);
        int stop_at;
        int pick;
        int len;
        stop_at = rx_count + quota;
        while (rx_count < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_valid_frame();
            else if (pick < 78)
                repeat ($urandom_range(1, 4))
                    send_rx_byte(8'($urandom_range(255)));
            else if (pick < 86)
                send_frame(sb.speed_id, {1'b0, sb.speed_size},
                           sb.end_byte ^ 8'($urandom_range(1, 255)));
            else if (pick < 92)
            begin
                len = $urandom_range(0, 70);
                if (len == sb.pose_size)
                    len++;
                send_frame(sb.pose_id, 8'(len), sb.end_byte);
            end
            else if (pick < 96)
                send_frame(8'($urandom_range(255)), {1'b0, sb.pose_size}, sb.end_byte);
            else
                send_frame(sb.pose_id, 8'($urandom_range(65, 130)), sb.end_byte);
        end
    endtask

    // Register write; the caller lowers the write enable after a group.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic write_all_regs(input logic [7:0] sof, input logic [7:0] eof,
                                  input logic [7:0] p_id, input logic [7:0] p_size,
                                  input logic [7:0] s_id, input logic [7:0] s_size);
        write_reg(CFG_START_BYTE, sof);
        write_reg(CFG_END_BYTE, eof);
        write_reg(CFG_POSE_ID, p_id);
        write_reg(CFG_POSE_SIZE, p_size);
        write_reg(CFG_SPEED_ID, s_id);
        write_reg(CFG_SPEED_SIZE, s_size);
    endtask

    // Stops offering until every expected result has arrived, then settles.
    // The first edge lets the monitor take the last byte offered.
    task automatic wait_for_drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_START_BYTE;
        cfg_data  <= 8'h00;
        push      <= 1'b0;
        rx_byte   <= 8'h00;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames at the reset configuration.
        foreach (directed_stream[i])
            send_rx_byte(directed_stream[i]);
        wait_for_drain();

        // A zero size accepts a zero-length frame without any result.
        write_reg(CFG_POSE_SIZE, 8'h00);
        cfg_we <= 1'b0;
        send_frame(8'h00, 8'h00, 8'h00);
        wait_for_drain();

        // Random settings with small sizes.
        write_all_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(1, 8)),
                       8'($urandom_range(255)), 8'($urandom_range(1, 8)));
        cfg_we <= 1'b0;
        send_random_traffic(100);
        wait_for_drain();

        // Extreme register values, full-size pose frames.
        send_idle_pct = 50;
        recv_idle_pct = 36;
        write_all_regs(8'hFF, 8'h00, 8'h00, 8'd64, 8'hFF, 8'd1);
        cfg_we <= 1'b0;
        send_random_traffic(80);
        wait_for_drain();

        // Equal ids, sizes written with the top bit set, writes past the list.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        begin
            logic [7:0] shared_id;
            shared_id = 8'($urandom_range(255));
            write_all_regs(8'($urandom_range(255)), 8'hFF, shared_id,
                           8'h80 | 8'($urandom_range(1, 6)), shared_id,
                           8'h80 | 8'($urandom_range(1, 6)));
        end
        write_reg(CFG_SPARE_LO, 8'($urandom_range(255)));
        write_reg(CFG_SPARE_HI, 8'($urandom_range(255)));
        cfg_we <= 1'b0;
        send_random_traffic(90);

        // Long receiver stall while accepted frames keep coming, so the input
        // backs up.
        hold_off_left = HOLD_OFF_LEN;
        repeat (8)
            send_frame(sb.pose_id, {1'b0, sb.pose_size}, sb.end_byte);
        wait_for_drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
